// ----- hw/rtl/mbct_pkg.sv -----
// Shared types and constants for the moving box collision test.
package mbct_pkg;

    localparam int          TOL_W       = 8;
    localparam logic [7:0]  TOL_RESET   = 8'd1;
    localparam logic        REG_TOL_IDX = 1'b0;
    localparam int          APB_AW      = 3;
    localparam int          APB_DW      = 32;
    localparam int          OUT_DW      = 8;

    typedef struct packed {
        logic mov;
        logic st_ok;
        logic lo_pos;
        logic hi_neg;
        logic lo_sat;
        logic hi_sat;
    } mbct_axis_t;

    typedef struct packed {
        logic       swept_ok;
        mbct_axis_t ay;
        mbct_axis_t ax;
    } mbct_ctl_t;

endpackage

// ----- hw/rtl/moving_box_collision_test.sv -----
// Swept collision test for two moving square boxes: one pair in, one verdict out.
// Takes one box pair per clock while the output is not stalled, and returns one collide bit per pair, in order.
// A pair passes through the front register, the queue, the divider stages and the result
// register; the pipelined time dividers set the depth, and a 4-entry queue decouples the
// classifier from the divider pipe.
// The tolerance register (address 0, reset 1) must only be written while idle.
module moving_box_collision_test
    import mbct_pkg::*;
#(
    parameter int COORD_INT_BITS  = 12,
    parameter int COORD_FRAC_BITS = 12,
    parameter int TIME_FRAC_BITS  = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, a_side,
    // b_start_x, b_start_y, b_end_x, b_end_y, b_side (lowest first)
    input  logic [((10*(COORD_INT_BITS+COORD_FRAC_BITS)+7)/8)*8-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // collide
    output logic [OUT_DW-1:0]        m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int CW = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int RW = CW + 3;
    localparam int DW = CW + 2;
    localparam int PW = $bits(mbct_ctl_t) + 4 * RW + 2 * DW;

    logic [TOL_W-1:0] tol_reg, tol_next;
    logic             f_valid, q_full, q_ne, q_pop;
    mbct_ctl_t        f_ctl, b_ctl;
    logic [RW-1:0]    f_nlo [2], f_nhi [2], b_nlo [2], b_nhi [2];
    logic [DW-1:0]    f_den [2], b_den [2];
    logic [PW-1:0]    q_wdata, q_rdata;
    logic             hit;

    assign pready = 1'b1;

    always_comb begin
        tol_next = tol_reg;
        if (psel && penable && pwrite && paddr[2] == REG_TOL_IDX) begin
            tol_next = pwdata[TOL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else begin
            tol_reg <= tol_next;
        end
    end

    assign prdata = (paddr[2] == REG_TOL_IDX) ? {{(APB_DW-TOL_W){1'b0}}, tol_reg} : '0;

    mbct_front #(.CW(CW), .RW(RW), .DW(DW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata[10*CW-1:0]), .tol(tol_reg),
        .out_valid(f_valid), .out_ready(!q_full),
        .out_ctl(f_ctl), .out_nlo(f_nlo), .out_nhi(f_nhi), .out_den(f_den)
    );

    assign q_wdata = {f_ctl, f_nlo[0], f_nhi[0], f_nlo[1], f_nhi[1], f_den[0], f_den[1]};
    assign {b_ctl, b_nlo[0], b_nhi[0], b_nlo[1], b_nhi[1], b_den[0], b_den[1]} = q_rdata;

    mbct_queue #(.WIDTH(PW), .DEPTH(4)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(f_valid && !q_full), .wdata(q_wdata), .full(q_full),
        .pop(q_pop), .rdata(q_rdata), .not_empty(q_ne)
    );

    mbct_back #(.RW(RW), .DW(DW), .TF(TIME_FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_ne), .in_pop(q_pop), .in_ctl(b_ctl),
        .in_nlo(b_nlo), .in_nhi(b_nhi), .in_den(b_den),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_hit(hit)
    );

    assign m_tdata = {{(OUT_DW-1){1'b0}}, hit};

endmodule

// ----- hw/rtl/mbct_front.sv -----
// Front stage: swept rejection, per-axis classification and divider operands.
module mbct_front
    import mbct_pkg::*;
#(
    parameter int CW = 24,
    parameter int RW = CW + 3,
    parameter int DW = CW + 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [10*CW-1:0]    in_data,
    input  logic [TOL_W-1:0]    tol,
    output logic                out_valid,
    input  logic                out_ready,
    output mbct_ctl_t           out_ctl,
    output logic [RW-1:0]       out_nlo [2],
    output logic [RW-1:0]       out_nhi [2],
    output logic [DW-1:0]       out_den [2]
);

    localparam int W = CW + 4;

    logic [CW-1:0] a0 [2], a1 [2], b0 [2], b1 [2];
    logic [CW-1:0] as_v, bs_v;
    logic          sw_ok [2];
    mbct_axis_t    ax_c [2];
    logic [RW-1:0] nlo_c [2], nhi_c [2];
    logic [DW-1:0] den_c [2];

    logic          valid_reg, valid_next;
    mbct_ctl_t     ctl_reg;
    logic [RW-1:0] nlo_reg [2], nhi_reg [2];
    logic [DW-1:0] den_reg [2];

    assign a0[0] = in_data[0*CW +: CW];
    assign a0[1] = in_data[1*CW +: CW];
    assign a1[0] = in_data[2*CW +: CW];
    assign a1[1] = in_data[3*CW +: CW];
    assign as_v  = in_data[4*CW +: CW];
    assign b0[0] = in_data[5*CW +: CW];
    assign b0[1] = in_data[6*CW +: CW];
    assign b1[0] = in_data[7*CW +: CW];
    assign b1[1] = in_data[8*CW +: CW];
    assign bs_v  = in_data[9*CW +: CW];

    for (genvar g = 0; g < 2; g++) begin : g_axis
        logic [CW:0]           amin, amax, bmin, bmax;
        logic signed [W-1:0]   sa0, sa1, sb0, sb1, sas, sbs, stol;
        logic signed [W-1:0]   d0, dv, nlo, nhi, nl, nh, twos;
        logic [DW-1:0]         s;
        logic                  zero_spd, lsat, hsat;

        always_comb begin
            amin = (a0[g] < a1[g]) ? {1'b0, a0[g]} : {1'b0, a1[g]};
            amax = ((a0[g] > a1[g]) ? {1'b0, a0[g]} : {1'b0, a1[g]}) + {1'b0, as_v};
            bmin = (b0[g] < b1[g]) ? {1'b0, b0[g]} : {1'b0, b1[g]};
            bmax = ((b0[g] > b1[g]) ? {1'b0, b0[g]} : {1'b0, b1[g]}) + {1'b0, bs_v};
            sw_ok[g] = (amin < bmax) && (amax > bmin);

            sa0  = $signed({{(W-CW){1'b0}}, a0[g]});
            sa1  = $signed({{(W-CW){1'b0}}, a1[g]});
            sb0  = $signed({{(W-CW){1'b0}}, b0[g]});
            sb1  = $signed({{(W-CW){1'b0}}, b1[g]});
            sas  = $signed({{(W-CW){1'b0}}, as_v});
            sbs  = $signed({{(W-CW){1'b0}}, bs_v});
            stol = $signed({{(W-TOL_W){1'b0}}, tol});

            d0 = sa0 - sb0;
            dv = (sa1 - sa0) - (sb1 - sb0);
            zero_spd = (dv == '0) || ((dv > -stol) && (dv < stol));
            s = dv[W-1] ? DW'(-dv) : DW'(dv);
            if (!dv[W-1]) begin
                nlo = -sas - d0;
                nhi = sbs - d0;
            end else begin
                nlo = d0 - sbs;
                nhi = d0 + sas;
            end
            nl   = nlo + stol;
            nh   = nhi - stol;
            twos = $signed({{(W-DW-1){1'b0}}, s, 1'b0});
            lsat = nl >= twos;
            hsat = nh >= twos;

            ax_c[g].mov    = !zero_spd;
            ax_c[g].st_ok  = (d0 > -sas + stol) && (d0 < sbs - stol);
            ax_c[g].lo_pos = nl > $signed(W'(0));
            ax_c[g].hi_neg = nh[W-1];
            ax_c[g].lo_sat = lsat;
            ax_c[g].hi_sat = hsat;
            nlo_c[g] = (nl[W-1] || lsat) ? '0 : RW'(nl);
            nhi_c[g] = (nh[W-1] || hsat) ? '0 : RW'(nh);
            den_c[g] = s;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg.swept_ok <= sw_ok[0] && sw_ok[1];
            ctl_reg.ax       <= ax_c[0];
            ctl_reg.ay       <= ax_c[1];
            nlo_reg          <= nlo_c;
            nhi_reg          <= nhi_c;
            den_reg          <= den_c;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_nlo   = nlo_reg;
    assign out_nhi   = nhi_reg;
    assign out_den   = den_reg;

endmodule

// ----- hw/rtl/mbct_queue.sv -----
// Short FIFO between the front stage and the divider back end.
module mbct_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             not_empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]      cnt_reg, cnt_next;

    assign full      = cnt_reg == (PW+1)'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign rdata     = mem_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop) begin
            rp_next = (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ----- hw/rtl/mbct_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module mbct_div #(
    parameter int RW = 27,
    parameter int DW = 26,
    parameter int QW = 17
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [RW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic          rem_nz
);

    logic [RW-1:0] r_reg [QW];
    logic [QW-1:0] q_reg [QW];
    logic [DW-1:0] d_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] t;
        logic [RW-1:0] dx;
        logic          ge;
        logic [QW-1:0] qi;
        logic [DW-1:0] di;

        always_comb begin
            if (k == 0) begin
                t  = num;
                qi = '0;
                di = den;
            end else begin
                t  = {r_reg[(k == 0) ? 0 : k-1][RW-2:0], 1'b0};
                qi = q_reg[(k == 0) ? 0 : k-1];
                di = d_reg[(k == 0) ? 0 : k-1];
            end
            dx = {{(RW-DW){1'b0}}, di};
            ge = t >= dx;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k] <= ge ? t - dx : t;
                q_reg[k] <= {qi[QW-2:0], ge};
                d_reg[k] <= di;
            end
        end
    end

    assign quo    = q_reg[QW-1];
    assign rem_nz = r_reg[QW-1] != '0;

endmodule

// ----- hw/rtl/mbct_back.sv -----
// Back end: four dividers, window clamping and the result register.
module mbct_back
    import mbct_pkg::*;
#(
    parameter int RW = 27,
    parameter int DW = 26,
    parameter int TF = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_pop,
    input  mbct_ctl_t         in_ctl,
    input  logic [RW-1:0]     in_nlo [2],
    input  logic [RW-1:0]     in_nhi [2],
    input  logic [DW-1:0]     in_den [2],
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_hit
);

    localparam int QW = TF + 1;
    localparam int LW = TF + 2;
    localparam logic [LW-1:0] T1  = LW'(1) << TF;
    localparam logic [LW-1:0] T1P = T1 + LW'(1);

    logic          adv;
    logic          v_reg [QW];
    mbct_ctl_t     c_reg [QW];
    logic [QW-1:0] qlo [2], qhi [2];
    logic          nzlo [2], nzhi [2];
    logic [LW-1:0] lo [2], hi [2];
    logic          ok [2];
    mbct_axis_t    ac [2];
    logic [LW-1:0] lo_m, hi_m;
    logic          hit;
    logic          ov_reg, ov_next;
    logic          hit_reg;

    assign adv    = !ov_reg || out_ready;
    assign in_pop = adv && in_valid;

    for (genvar g = 0; g < 2; g++) begin : g_div
        mbct_div #(.RW(RW), .DW(DW), .QW(QW)) u_lo (
            .aclk(aclk), .en(adv), .num(in_nlo[g]), .den(in_den[g]),
            .quo(qlo[g]), .rem_nz(nzlo[g])
        );
        mbct_div #(.RW(RW), .DW(DW), .QW(QW)) u_hi (
            .aclk(aclk), .en(adv), .num(in_nhi[g]), .den(in_den[g]),
            .quo(qhi[g]), .rem_nz(nzhi[g])
        );
    end

    for (genvar k = 0; k < QW; k++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                c_reg[k] <= (k == 0) ? in_ctl : c_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign ac[0] = c_reg[QW-1].ax;
    assign ac[1] = c_reg[QW-1].ay;

    for (genvar g = 0; g < 2; g++) begin : g_win
        logic [LW-1:0] cl, fl;
        always_comb begin
            cl = {1'b0, qlo[g]} + {{(LW-1){1'b0}}, nzlo[g]};
            fl = {1'b0, qhi[g]};
            if (ac[g].mov) begin
                if (!ac[g].lo_pos) begin
                    lo[g] = '0;
                end else if (ac[g].lo_sat || cl > T1P) begin
                    lo[g] = T1P;
                end else begin
                    lo[g] = cl;
                end
                hi[g] = (ac[g].hi_sat || fl > T1) ? T1 : fl;
                ok[g] = !ac[g].hi_neg && (lo[g] <= hi[g]);
            end else begin
                lo[g] = '0;
                hi[g] = T1;
                ok[g] = ac[g].st_ok;
            end
        end
    end

    always_comb begin
        lo_m = (lo[0] > lo[1]) ? lo[0] : lo[1];
        hi_m = (hi[0] < hi[1]) ? hi[0] : hi[1];
        hit  = c_reg[QW-1].swept_ok && ok[0] && ok[1] && (lo_m <= hi_m);
        ov_next = adv ? v_reg[QW-1] : ov_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg <= hit;
        end
    end

    assign out_valid = ov_reg;
    assign out_hit   = hit_reg;

endmodule

// ----- hw/rtl/mbct_checker.sv -----
// Port-level checks for the moving box collision test, bound to the top level.
module mbct_checker
    import mbct_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_DW-1:0] m_tdata,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata
);

    a_rst_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat dropped or changed");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DW-1:1] == '0)
        else $error("result padding bits not zero");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && paddr[2] == REG_TOL_IDX |=>
            paddr[2] != REG_TOL_IDX || prdata == {24'd0, $past(pwdata[7:0])})
        else $error("tolerance readback differs from last write");

endmodule

bind moving_box_collision_test mbct_checker u_mbct_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata)
);

// ----- dv/moving_box_collision_test_checker.sv -----
// Checker for the moving box collision test: predicts and compares each collide beat.
`timescale 1ns / 1ps
module moving_box_collision_test_checker
    import mbct_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [239:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending
);
    localparam longint T_ONE = 64'sd65536;
    localparam longint T_SAT = 64'sd131072;

    logic [7:0] tol_q;
    bit         verdict_mem [1024];
    int         wr_cnt;
    int         rd_cnt;

    assign pending = wr_cnt - rd_cnt;

    function automatic longint sat_t(longint t);
        if (t < -T_SAT) return -T_SAT;
        if (t > T_SAT - 1) return T_SAT - 1;
        return t;
    endfunction

    function automatic longint fdiv(longint n, longint s);
        longint q;
        q = n / s;
        if (n % s != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint cdiv(longint n, longint s);
        longint q;
        q = n / s;
        if (n % s != 0 && n > 0) q++;
        return q;
    endfunction

    function automatic bit time_window(longint d0, longint dv, longint lower,
                                       longint upper, longint tol,
                                       output longint lo, output longint hi);
        longint s, nlo, nhi;
        lo = 0;
        hi = T_ONE;
        if (dv == 0 || (dv > -tol && dv < tol))
            return (d0 > lower + tol) && (d0 < upper - tol);
        if (dv > 0) begin
            s = dv; nlo = lower - d0; nhi = upper - d0;
        end else begin
            s = -dv; nlo = d0 - upper; nhi = d0 - lower;
        end
        lo = sat_t(cdiv((nlo + tol) * T_ONE, s));
        hi = sat_t(fdiv((nhi - tol) * T_ONE, s));
        if (lo < 0) lo = 0;
        if (hi > T_ONE) hi = T_ONE;
        return lo <= hi;
    endfunction

    function automatic bit swept_hit(longint a0, longint a1, longint as,
                                     longint b0, longint b1, longint bs);
        longint amin, amax, bmin, bmax;
        amin = a0 < a1 ? a0 : a1;
        amax = (a0 > a1 ? a0 : a1) + as;
        bmin = b0 < b1 ? b0 : b1;
        bmax = (b0 > b1 ? b0 : b1) + bs;
        return amin < bmax && amax > bmin;
    endfunction

    function automatic logic boxes_collide(logic [239:0] d, logic [7:0] tol8);
        longint f[10];
        longint xlo, xhi, ylo, yhi, tol;
        for (int i = 0; i < 10; i++) f[i] = longint'(d[24*i +: 24]);
        tol = longint'(tol8);
        if (!swept_hit(f[0], f[2], f[4], f[5], f[7], f[9])) return 1'b0;
        if (!swept_hit(f[1], f[3], f[4], f[6], f[8], f[9])) return 1'b0;
        if (!time_window(f[0] - f[5], (f[2] - f[0]) - (f[7] - f[5]), -f[4], f[9],
                         tol, xlo, xhi)) return 1'b0;
        if (!time_window(f[1] - f[6], (f[3] - f[1]) - (f[8] - f[6]), -f[4], f[9],
                         tol, ylo, yhi)) return 1'b0;
        return ((xlo > ylo ? xlo : ylo) <= (xhi < yhi ? xhi : yhi));
    endfunction

    always @(posedge aclk) begin
        logic want;
        if (!aresetn) begin
            tol_q      <= TOL_RESET;
            fail_count <= 0;
            wr_cnt     = 0;
            rd_cnt     = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_TOL_IDX)
                tol_q <= pwdata[7:0];
            if (s_tvalid && s_tready) begin
                verdict_mem[wr_cnt[9:0]] = boxes_collide(s_tdata, tol_q);
                wr_cnt++;
            end
            if (m_tvalid && m_tready) begin
                if (wr_cnt == rd_cnt) begin
                    $error("collide: unexpected beat, actual %0b", m_tdata[0]);
                    fail_count <= fail_count + 1;
                end else begin
                    want = verdict_mem[rd_cnt[9:0]];
                    rd_cnt++;
                    if (m_tdata[0] !== want) begin
                        $error("collide: expected %0b, actual %0b", want, m_tdata[0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/moving_box_collision_test_tb.sv -----
// Testbench top for the moving box collision test: stimulus, config and verdict.
`timescale 1ns / 1ps
module moving_box_collision_test_tb;
    import mbct_pkg::*;

    localparam int DRAIN = 40;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [239:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;
    bit           hold_off = 1'b0;

    always #5 aclk = ~aclk;

    moving_box_collision_test u_top (.*);

    moving_box_collision_test_checker u_chk (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [23:0] coord_near(logic [23:0] base);
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return base + 24'($urandom_range(0, 8192)) - 24'd4096;
            2: return base + 24'($urandom_range(0, 8)) - 24'd4;
            default: return base;
        endcase
    endfunction

    function automatic logic [239:0] random_pair();
        logic [23:0] f[10];
        logic [239:0] d;
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 10; i++) f[i] = 24'($urandom);
        end else begin
            f[0] = 24'($urandom_range(0, 24'hFFFFFF));
            f[1] = 24'($urandom_range(0, 24'hFFFFFF));
            f[2] = coord_near(f[0]);
            f[3] = coord_near(f[1]);
            f[4] = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 16384));
            f[9] = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 16384));
            for (int i = 0; i < 4; i++) f[5 + i] = coord_near(f[i]);
        end
        for (int i = 0; i < 10; i++) d[24*i +: 24] = f[i];
        return d;
    endfunction

    function automatic logic [239:0] pack_pair(logic [23:0] ax0, logic [23:0] ay0,
            logic [23:0] ax1, logic [23:0] ay1, logic [23:0] as, logic [23:0] bx0,
            logic [23:0] by0, logic [23:0] bx1, logic [23:0] by1, logic [23:0] bs);
        return {bs, by1, bx1, by0, bx0, as, ay1, ax1, ay0, ax0};
    endfunction

    task automatic send_pair(logic [239:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_tol(logic [7:0] v);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_TOL_IDX);
        pwdata  <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic directed_set();
        send_pair('0);
        send_pair('1);
        send_pair(pack_pair(0, 0, 0, 0, 4096, 0, 0, 0, 0, 4096));
        send_pair(pack_pair(0, 0, 0, 0, 4096, 4096, 0, 4096, 0, 4096));
        send_pair(pack_pair(0, 0, 0, 0, 4096, 4095, 0, 4095, 0, 4096));
        send_pair(pack_pair(0, 0, 40960, 0, 4096, 20480, 0, 20480, 0, 4096));
        send_pair(pack_pair(0, 0, 40960, 40960, 4096, 40960, 0, 0, 40960, 4096));
        send_pair(pack_pair(0, 0, 40960, 40960, 4096, 40960, 40960, 0, 0, 4096));
        send_pair(pack_pair(24'hFFFFFF, 0, 0, 24'hFFFFFF, 24'hFFFFFF,
                            0, 24'hFFFFFF, 24'hFFFFFF, 0, 24'hFFFFFF));
        send_pair(pack_pair(100, 100, 101, 100, 50, 100, 100, 100, 100, 50));
        send_pair(pack_pair(0, 0, 8192, 0, 4096, 12288, 0, 12288, 0, 4096));
        send_pair(pack_pair(0, 0, 8191, 0, 4096, 12288, 0, 12288, 0, 4096));
        send_pair(pack_pair(8192, 0, 0, 0, 4096, 0, 0, 0, 0, 4096));
        send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pack_pair(24'hFFF000, 24'hFFF000, 0, 0, 4096,
                            0, 0, 24'hFFF000, 24'hFFF000, 4096));
    endtask

    always @(posedge aclk) begin
        int stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall = 0;
        end else if (hold_off) begin
            m_tready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = gap_len();
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [7:0] tols[5];
        tols = '{8'd0, 8'd255, 8'd1, 8'd17, 8'd4};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_set();
        for (int p = 0; p < 5; p++) begin
            write_tol(tols[p]);
            if (p == 0) directed_set();
            if (p == 1) begin
                hold_off <= 1'b1;
                fork
                    begin
                        repeat (200) @(posedge aclk);
                        hold_off <= 1'b0;
                    end
                    for (int i = 0; i < 60; i++) send_pair(random_pair());
                join
            end
            for (int i = 0; i < 150; i++) send_pair(random_pair());
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
